### hdl/gnms_pkg.sv
// Shared definitions for the gradient non-maximum suppression block.
// Holds default field widths and the direction class codes.
// No dependencies.
package gnms_pkg;

  localparam int MAG_BITS_DEF  = 11;
  localparam int GRAD_BITS_DEF = 11;

  // Direction class of the gradient, picked from signs and magnitudes
  typedef enum logic [2:0] {
    DIR_VERT       = 3'd0,  // ratio infinite or undefined: south / north
    DIR_HORZ       = 3'd1,  // ratio zero: west / east
    DIR_DIAG_MAIN  = 3'd2,  // ratio +1: northwest / southeast
    DIR_DIAG_ANTI  = 3'd3,  // ratio -1: northeast / southwest
    DIR_STEEP_SAME = 3'd4,  // |gx| < |gy|, same signs
    DIR_STEEP_OPP  = 3'd5,  // |gx| < |gy|, opposite signs
    DIR_FLAT_SAME  = 3'd6,  // |gx| > |gy|, same signs
    DIR_FLAT_OPP   = 3'd7   // |gx| > |gy|, opposite signs
  } dir_e;

endpackage

### hdl/gnms_if.sv
// Valid/ready channel interfaces for the non-maximum suppression block.
// Depends on gnms_pkg for default widths.
interface gnms_in_if #(
  parameter int MAG_BITS  = gnms_pkg::MAG_BITS_DEF,
  parameter int GRAD_BITS = gnms_pkg::GRAD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic        [MAG_BITS-1:0]  mag_center;
  logic        [MAG_BITS-1:0]  mag_west;
  logic        [MAG_BITS-1:0]  mag_east;
  logic        [MAG_BITS-1:0]  mag_north;
  logic        [MAG_BITS-1:0]  mag_south;
  logic        [MAG_BITS-1:0]  mag_northwest;
  logic        [MAG_BITS-1:0]  mag_northeast;
  logic        [MAG_BITS-1:0]  mag_southwest;
  logic        [MAG_BITS-1:0]  mag_southeast;
  logic signed [GRAD_BITS-1:0] grad_x;
  logic signed [GRAD_BITS-1:0] grad_y;

  modport source (
    output valid, mag_center, mag_west, mag_east, mag_north, mag_south,
           mag_northwest, mag_northeast, mag_southwest, mag_southeast,
           grad_x, grad_y,
    input  ready
  );
  modport sink (
    input  valid, mag_center, mag_west, mag_east, mag_north, mag_south,
           mag_northwest, mag_northeast, mag_southwest, mag_southeast,
           grad_x, grad_y,
    output ready
  );
endinterface

interface gnms_out_if #(
  parameter int MAG_BITS = gnms_pkg::MAG_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] thinned_mag;
  logic                is_maximum;

  modport source (output valid, thinned_mag, is_maximum, input ready);
  modport sink   (input valid, thinned_mag, is_maximum, output ready);
endinterface

### hdl/gradient_non_max_suppression.sv
// Gradient non-maximum suppression: one pixel window in, one thinned magnitude out.
// Depends on gnms_pkg and the channel interfaces in gnms_if.sv.
//
// Usage:
//   in_i carries one item per pixel: the 3x3 gradient-magnitude window around
//   the pixel and its signed x and y gradients. out_o returns one item per
//   input item, in order: the centre magnitude when it is a local maximum
//   along the gradient direction, else zero, plus an is_maximum flag.
//   There are three register stages (classify, select sides, compare); out_o
//   is driven straight from the compare-stage registers. Throughput is one
//   item per cycle: a new item may be accepted at every clock edge while the
//   pipeline keeps flowing.
//   When the receiver holds out_o.ready low, each stage holds its item only if
//   the stage after it is full and stalled, so bubbles are squeezed out and
//   in_i.ready drops only once all three stages hold items. Nothing is lost
//   or repeated across a stall.
//   Reset clears the stage valid bits; the block accepts items as soon as
//   reset is released. The block keeps no state between items.
module gradient_non_max_suppression #(
  parameter int MAG_BITS  = gnms_pkg::MAG_BITS_DEF,
  parameter int GRAD_BITS = gnms_pkg::GRAD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gnms_in_if.sink           in_i,
  gnms_out_if.source        out_o
);
  import gnms_pkg::*;

  localparam int SUM_BITS = MAG_BITS + 1;

  // ---------------------------------------------------------------------------
  // Stall control: a stage advances when it is empty or its successor advances
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3        = !v3_q || out_o.ready;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;

  // ---------------------------------------------------------------------------
  // Stage 1: classify the direction from signs and absolute values
  // ---------------------------------------------------------------------------
  logic [GRAD_BITS-1:0] abs_x, abs_y;
  logic                 same_sign;
  dir_e                 dir_d;

  assign abs_x     = in_i.grad_x[GRAD_BITS-1] ? GRAD_BITS'(-in_i.grad_x)
                                               : GRAD_BITS'(in_i.grad_x);
  assign abs_y     = in_i.grad_y[GRAD_BITS-1] ? GRAD_BITS'(-in_i.grad_y)
                                               : GRAD_BITS'(in_i.grad_y);
  assign same_sign = (in_i.grad_x[GRAD_BITS-1] == in_i.grad_y[GRAD_BITS-1]);

  always_comb begin
    if (in_i.grad_y == '0) begin
      dir_d = DIR_VERT;
    end else if (in_i.grad_x == '0) begin
      dir_d = DIR_HORZ;
    end else if (abs_x == abs_y) begin
      dir_d = same_sign ? DIR_DIAG_MAIN : DIR_DIAG_ANTI;
    end else if (abs_x < abs_y) begin
      dir_d = same_sign ? DIR_STEEP_SAME : DIR_STEEP_OPP;
    end else begin
      dir_d = same_sign ? DIR_FLAT_SAME : DIR_FLAT_OPP;
    end
  end

  dir_e                dir_q;
  logic [MAG_BITS-1:0] c1_q, w1_q, e1_q, n1_q, s1_q, nw1_q, ne1_q, sw1_q, se1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dir_q <= dir_d;
      c1_q  <= in_i.mag_center;
      w1_q  <= in_i.mag_west;
      e1_q  <= in_i.mag_east;
      n1_q  <= in_i.mag_north;
      s1_q  <= in_i.mag_south;
      nw1_q <= in_i.mag_northwest;
      ne1_q <= in_i.mag_northeast;
      sw1_q <= in_i.mag_southwest;
      se1_q <= in_i.mag_southeast;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: form both sides at double scale. A single neighbour is doubled so
  // that every class compares 2*centre against a side.
  // ---------------------------------------------------------------------------
  logic [SUM_BITS-1:0] side_a_d, side_b_d;

  function automatic logic [SUM_BITS-1:0] pair_sum(input logic [MAG_BITS-1:0] p,
                                                   input logic [MAG_BITS-1:0] r);
    return SUM_BITS'(p) + SUM_BITS'(r);
  endfunction

  always_comb begin
    case (dir_q)
      DIR_VERT: begin
        side_a_d = {s1_q, 1'b0};
        side_b_d = {n1_q, 1'b0};
      end
      DIR_HORZ: begin
        side_a_d = {w1_q, 1'b0};
        side_b_d = {e1_q, 1'b0};
      end
      DIR_DIAG_MAIN: begin
        side_a_d = {nw1_q, 1'b0};
        side_b_d = {se1_q, 1'b0};
      end
      DIR_DIAG_ANTI: begin
        side_a_d = {ne1_q, 1'b0};
        side_b_d = {sw1_q, 1'b0};
      end
      DIR_STEEP_SAME: begin
        side_a_d = pair_sum(se1_q, e1_q);
        side_b_d = pair_sum(nw1_q, w1_q);
      end
      DIR_STEEP_OPP: begin
        side_a_d = pair_sum(sw1_q, w1_q);
        side_b_d = pair_sum(ne1_q, e1_q);
      end
      DIR_FLAT_SAME: begin
        side_a_d = pair_sum(s1_q, se1_q);
        side_b_d = pair_sum(n1_q, nw1_q);
      end
      DIR_FLAT_OPP: begin
        side_a_d = pair_sum(s1_q, sw1_q);
        side_b_d = pair_sum(n1_q, ne1_q);
      end
      default: begin
        side_a_d = '0;
        side_b_d = '0;
      end
    endcase
  end

  logic [SUM_BITS-1:0] side_a_q, side_b_q;
  logic [MAG_BITS-1:0] c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      side_a_q <= side_a_d;
      side_b_q <= side_b_d;
      c2_q     <= c1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: compare doubled centre against both sides, register the result
  // ---------------------------------------------------------------------------
  logic [SUM_BITS-1:0] c_dbl;
  logic                keep_d;

  assign c_dbl  = {c2_q, 1'b0};
  assign keep_d = (c_dbl >= side_a_q) && (c_dbl >= side_b_q);

  logic [MAG_BITS-1:0] thinned_q;
  logic                is_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      thinned_q <= keep_d ? c2_q : '0;
      is_max_q  <= keep_d;
    end
  end

  assign out_o.valid       = v3_q;
  assign out_o.thinned_mag = thinned_q;
  assign out_o.is_maximum  = is_max_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // A suppressed pixel always reads as zero magnitude
  a_suppressed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !is_max_q) |-> (thinned_q == '0))
    else $error("suppressed item carries nonzero magnitude");

  // An accepted item lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted item lost at stage 1");

  // A stalled middle stage holds its item and its sides
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en2) |=> (v2_q && $stable(side_a_q) && $stable(side_b_q)))
    else $error("stage 2 item changed during stall");

  // Ready drops only when every stage is full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && !out_o.ready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
